### hw/rtl/amlf_pkg.sv
// Shared types and constants for the AT modem line framer.
// Depends on nothing; imported by amlf_front, amlf_back and the top level.
package amlf_pkg;

   // Sizing
   localparam int LINE_BYTES   = 64;
   localparam int PREFIX_BYTES = 64;
   localparam int LINE_CAP     = LINE_BYTES - 1;
   localparam int PREFIX_CAP   = PREFIX_BYTES - 1;
   localparam int LINE_AW      = $clog2(LINE_BYTES);
   localparam int PREFIX_AW    = $clog2(PREFIX_BYTES);

   // Fixed field widths of the request
   localparam int BYTE_W  = 8;
   localparam int CMD_W   = 3;
   localparam int TIDX_W  = 6;
   localparam int TLEN_W  = 6;
   localparam int REQ_DATA_W = 24;

   // Common width for mixed-size compares
   localparam int CMP_W0 = (LINE_AW > PREFIX_AW) ? LINE_AW : PREFIX_AW;
   localparam int CMP_W  = ((CMP_W0 > TIDX_W) ? CMP_W0 : TIDX_W) + 1;

   // Front queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;

   // Characters
   localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

   // Request command codes
   localparam logic [CMD_W-1:0] CMD_RX       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FLUSH    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_WR_TRIG  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ARM      = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DISARM   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_RAW_ON   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RAW_OFF  = 3'd6;

   // Result kinds
   localparam logic KIND_LINE = 1'b0;
   localparam logic KIND_RAW  = 1'b1;

   // Classified operations handed from front to back
   typedef enum logic [2:0] {
      OP_RX_CHAR,
      OP_RX_LF,
      OP_FLUSH,
      OP_WR_TRIG,
      OP_ARM,
      OP_DISARM,
      OP_RAW_ON,
      OP_RAW_OFF
   } op_code_type;

   typedef struct packed {
      op_code_type            code;
      logic [BYTE_W-1:0]      data;
      logic [PREFIX_AW-1:0]   index;
      logic [PREFIX_AW-1:0]   length;
   } op_type;

endpackage

### hw/rtl/amlf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module amlf_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/amlf_front.sv
// Front end: accepts request transfers, classifies commands, queues ops.
// Depends on amlf_pkg.
module amlf_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [amlf_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [amlf_pkg::CMD_W-1:0]       req_tuser,
   output logic                             q_valid,
   input  logic                             q_ready,
   output amlf_pkg::op_type                 q_op
);
   import amlf_pkg::*;

   op_type               queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]    fill_ff, fill_in;

   logic [BYTE_W-1:0]    data_byte;
   logic [TIDX_W-1:0]    trig_index;
   logic [TLEN_W-1:0]    trig_length;
   op_type               dec_op;
   logic                 keep;
   logic                 push, pop;

   assign data_byte   = req_tdata[7:0];
   assign trig_index  = req_tdata[13:8];
   assign trig_length = req_tdata[19:14];

   // Classify: split rx into newline / other, drop no-op commands,
   // saturate the arm length.
   always_comb begin
      keep          = 1'b1;
      dec_op.code   = OP_RX_CHAR;
      dec_op.data   = data_byte;
      dec_op.index  = PREFIX_AW'(trig_index);
      if (CMP_W'(trig_length) > CMP_W'(PREFIX_CAP)) begin
         dec_op.length = PREFIX_AW'(PREFIX_CAP);
      end else begin
         dec_op.length = PREFIX_AW'(trig_length);
      end
      case (req_tuser)
         CMD_RX: begin
            dec_op.code = (data_byte == CH_LF) ? OP_RX_LF : OP_RX_CHAR;
         end
         CMD_FLUSH:   dec_op.code = OP_FLUSH;
         CMD_WR_TRIG: begin
            dec_op.code = OP_WR_TRIG;
            keep = (CMP_W'(trig_index) < CMP_W'(PREFIX_CAP));
         end
         CMD_ARM:     dec_op.code = OP_ARM;
         CMD_DISARM:  dec_op.code = OP_DISARM;
         CMD_RAW_ON:  dec_op.code = OP_RAW_ON;
         CMD_RAW_OFF: dec_op.code = OP_RAW_OFF;
         default:     keep = 1'b0;
      endcase
   end

   assign req_tready = (fill_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign q_valid    = (fill_ff != '0);
   assign q_op       = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready && keep;
   assign pop        = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= dec_op;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### hw/rtl/amlf_back.sv
// Back end: line store, trigger store, line walk sequencer, result register.
// Depends on amlf_pkg and amlf_ram.
module amlf_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  amlf_pkg::op_type              q_op,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [amlf_pkg::BYTE_W-1:0]   rsp_tdata,
   output logic                          rsp_tlast,
   output logic [1:0]                    rsp_tuser
);
   import amlf_pkg::*;

   typedef enum logic {ST_IDLE, ST_WALK} state_type;

   state_type             state_ff, state_in;
   logic [LINE_AW-1:0]    count_ff, count_in;
   logic                  last_cr_ff, last_cr_in;
   logic [PREFIX_AW-1:0]  pc_ff, pc_in;
   logic                  armed_ff, armed_in;
   logic                  raw_ff, raw_in;
   logic                  pending_ff, pending_in;
   logic [LINE_AW-1:0]    idx_ff, idx_in;
   logic [LINE_AW-1:0]    n_ff, n_in;
   logic                  is_lf_ff, is_lf_in;
   logic [BYTE_W-1:0]     hold_ff, hold_in;
   logic                  mism_ff, mism_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]     rsp_byte_ff, rsp_byte_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic                  rsp_raw_ff, rsp_raw_in;

   logic                  line_we;
   logic [LINE_AW-1:0]    line_wa;
   logic [BYTE_W-1:0]     line_wd;
   logic [BYTE_W-1:0]     line_rd;
   logic                  pfx_we;
   logic [BYTE_W-1:0]     pfx_rd;

   logic                  out_free;
   logic                  pop;
   logic                  push;
   logic                  is_rx;
   logic [LINE_AW-1:0]    n_lf;

   amlf_ram #(.WIDTH(BYTE_W), .DEPTH(LINE_CAP), .ADDR_W(LINE_AW)) u_line_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (line_wa),
      .wr_data (line_wd),
      .rd_addr (idx_in),
      .rd_data (line_rd)
   );

   amlf_ram #(.WIDTH(BYTE_W), .DEPTH(PREFIX_CAP), .ADDR_W(PREFIX_AW)) u_prefix_ram (
      .clock   (clock),
      .wr_en   (pfx_we),
      .wr_addr (q_op.index),
      .wr_data (q_op.data),
      .rd_addr (PREFIX_AW'(idx_in)),
      .rd_data (pfx_rd)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign is_rx    = (q_op.code == OP_RX_CHAR) || (q_op.code == OP_RX_LF);
   // line length with one trailing CR dropped
   assign n_lf     = (count_ff != '0 && last_cr_ff) ? count_ff - LINE_AW'(1) : count_ff;
   assign pop      = q_valid && q_ready;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      last_cr_in  = last_cr_ff;
      pc_in       = pc_ff;
      armed_in    = armed_ff;
      raw_in      = raw_ff;
      pending_in  = pending_ff;
      idx_in      = idx_ff;
      n_in        = n_ff;
      is_lf_in    = is_lf_ff;
      hold_in     = hold_ff;
      mism_in     = mism_ff;
      line_we     = 1'b0;
      line_wa     = count_ff;
      line_wd     = q_op.data;
      pfx_we      = 1'b0;
      q_ready     = 1'b0;
      push        = 1'b0;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_raw_in  = rsp_raw_ff;

      case (state_ff)
         ST_IDLE: begin
            q_ready = !(raw_ff && is_rx) || out_free;
            if (pop) begin
               if (raw_ff && is_rx) begin
                  // raw passthrough
                  push        = 1'b1;
                  rsp_kind_in = KIND_RAW;
                  rsp_byte_in = q_op.data;
                  rsp_last_in = 1'b0;
                  rsp_raw_in  = 1'b1;
               end else begin
                  case (q_op.code)
                     OP_RX_LF: begin
                        count_in = '0;
                        if (n_lf == '0) begin
                           if (armed_ff && pc_ff == '0) begin
                              armed_in = 1'b0;
                              raw_in   = 1'b1;
                           end
                        end else begin
                           state_in = ST_WALK;
                           idx_in   = '0;
                           n_in     = n_lf;
                           is_lf_in = 1'b1;
                           mism_in  = 1'b0;
                        end
                     end
                     OP_RX_CHAR: begin
                        if (count_ff != LINE_AW'(LINE_CAP)) begin
                           line_we    = 1'b1;
                           count_in   = count_ff + LINE_AW'(1);
                           last_cr_in = (q_op.data == CH_CR);
                        end else begin
                           // full line goes out, this byte starts the next one
                           state_in = ST_WALK;
                           idx_in   = '0;
                           n_in     = count_ff;
                           is_lf_in = 1'b0;
                           hold_in  = q_op.data;
                           mism_in  = 1'b0;
                        end
                     end
                     OP_FLUSH: begin
                        if (raw_ff) begin
                           pending_in = 1'b1;
                        end else begin
                           count_in   = '0;
                           pending_in = 1'b0;
                        end
                     end
                     OP_WR_TRIG: pfx_we = 1'b1;
                     OP_ARM: begin
                        pc_in    = q_op.length;
                        armed_in = 1'b1;
                     end
                     OP_DISARM: armed_in = 1'b0;
                     OP_RAW_ON: raw_in = 1'b1;
                     OP_RAW_OFF: begin
                        raw_in = 1'b0;
                        if (pending_ff) begin
                           count_in   = '0;
                           pending_in = 1'b0;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         ST_WALK: begin
            if (out_free) begin
               push        = 1'b1;
               rsp_kind_in = KIND_LINE;
               rsp_byte_in = line_rd;
               rsp_last_in = (idx_ff == n_ff - LINE_AW'(1));
               rsp_raw_in  = raw_ff;
               mism_in     = mism_ff ||
                             ((CMP_W'(idx_ff) < CMP_W'(pc_ff)) && (line_rd != pfx_rd));
               if (idx_ff == n_ff - LINE_AW'(1)) begin
                  state_in = ST_IDLE;
                  if (is_lf_ff) begin
                     if (armed_ff && (CMP_W'(n_ff) >= CMP_W'(pc_ff)) && !mism_in) begin
                        armed_in = 1'b0;
                        raw_in   = 1'b1;
                     end
                  end else begin
                     line_we    = 1'b1;
                     line_wa    = '0;
                     line_wd    = hold_ff;
                     count_in   = LINE_AW'(1);
                     last_cr_in = (hold_ff == CH_CR);
                  end
               end else begin
                  idx_in = idx_ff + LINE_AW'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      last_cr_ff  <= last_cr_in;
      idx_ff      <= idx_in;
      n_ff        <= n_in;
      is_lf_ff    <= is_lf_in;
      hold_ff     <= hold_in;
      mism_ff     <= mism_in;
      pc_ff       <= pc_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_raw_ff  <= rsp_raw_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         armed_ff     <= 1'b0;
         raw_ff       <= 1'b0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         armed_ff     <= armed_in;
         raw_ff       <= raw_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_raw_ff, rsp_kind_ff};

   // a held flush only exists while raw mode is on
   a_pending_raw: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> raw_ff)
      else $error("flush pending outside raw mode");

   // the walk index stays inside the line being sent
   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (idx_ff < n_ff))
      else $error("line walk index out of range");

   // no op is taken from the queue while a line is being walked
   a_walk_no_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> !pop)
      else $error("queue popped during line walk");

   // the stored count never passes the line capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LINE_AW'(LINE_CAP))
      else $error("line count above capacity");

endmodule

### hw/rtl/at_modem_line_framer_unit.sv
// Top level of the AT modem line framer: request and result stream ports.
// Depends on amlf_pkg, amlf_front, amlf_back (and amlf_ram through amlf_back).

// The framer takes one command per request transfer (req_tuser selects it)
// and builds text lines from received bytes. A newline ends a line, one
// trailing carriage return is dropped, and a non-empty line leaves as a run
// of result transfers with rsp_tlast on its final byte. A line that holds 63
// bytes is sent when the next non-newline byte arrives; that byte starts the
// next line. An armed trigger compares the start of each ended line with the
// stored prefix; a match disarms it and turns on raw mode, in which every
// received byte goes straight out as a raw result (rsp_tuser[0] set). A
// flush in raw mode is held until raw mode ends. Timing: a front queue of
// two entries takes a request transfer per cycle while it has room. The back
// end takes one queued op per cycle while idle, unless a raw byte finds the
// result register full; a command that ends or overflows a line of n bytes
// holds the back end while it sends them, one stored byte per cycle out of
// the line-store read port when rsp_tready stays high. Raw and line bytes
// wait in the result register while the back end goes on only when that
// register is free. Neither store needs a clearing pass after reset.
module at_modem_line_framer_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] data_byte, [13:8] trigger_index,
                                    // [19:14] trigger_length, [23:20] zero
   input  logic [2:0]  req_tuser,   // [2:0] cmd
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // last_of_line
   output logic [1:0]  rsp_tuser    // [0] kind, [1] raw_active
);
   import amlf_pkg::*;

   logic   q_valid;
   logic   q_ready;
   op_type q_op;

   // classify and queue commands
   amlf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_op       (q_op)
   );

   // line state, trigger match and result output
   amlf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_op       (q_op),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### test/testbench.sv
// Self-checking testbench for at_modem_line_framer_unit: line assembly, overflow,
// trigger-to-raw switching and held flushes. Depends on amlf_pkg and the RTL only.
module testbench;
   import amlf_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
   localparam int unsigned ITEM_TARGET = 400;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned DRAIN_CYCLES = 80;      // settle time after the scoreboard empties
   localparam int unsigned CYCLE_LIMIT = 500000;   // far above the slowest legal run

   // One result transfer, unpacked into its fields.
   typedef struct packed {
      logic       kind;
      logic [7:0] value;
      logic       last;
      logic       raw;
   } framer_rsp_type;

   // Scoreboard: mirrors the framer state, queues the bytes each request
   // should produce, and checks result transfers against them in order.
   class line_framer_scoreboard;
      logic [7:0]  line_buf [LINE_CAP];
      int unsigned buf_count;
      logic [7:0]  trig_buf [PREFIX_CAP];
      int unsigned trig_count;
      bit          trig_armed;
      bit          in_raw;
      bit          flush_held;
      framer_rsp_type expected_q [$];
      int unsigned mismatches, results_seen, line_results, raw_results;
      int unsigned trigger_hits, overflows;

      function void queue_line(int unsigned n);
         for (int unsigned i = 0; i < n; i++)
            expected_q.push_back('{KIND_LINE, line_buf[i], (i + 1 == n), in_raw});
      endfunction

      // Line start vs. prefix; a zero-length prefix hits every newline.
      function bit prefix_hit(int unsigned n);
         if (!trig_armed || n < trig_count) return 1'b0;
         for (int unsigned i = 0; i < trig_count; i++)
            if (line_buf[i] !== trig_buf[i]) return 1'b0;
         return 1'b1;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [7:0] b,
                                 logic [5:0] idx, logic [5:0] len);
         int unsigned n;
         case (cmd)
            CMD_RX: begin
               if (in_raw) begin
                  expected_q.push_back('{KIND_RAW, b, 1'b0, 1'b1});
               end else if (b == CH_LF) begin
                  n = buf_count;
                  if (n > 0 && line_buf[n-1] == CH_CR) n--;   // drop one trailing CR
                  queue_line(n);
                  if (prefix_hit(n)) begin
                     trig_armed = 1'b0;
                     in_raw     = 1'b1;
                     trigger_hits++;
                  end
                  buf_count = 0;
               end else if (buf_count < LINE_CAP) begin
                  line_buf[buf_count] = b;
                  buf_count++;
               end else begin
                  // full line goes out, new byte starts the next one
                  queue_line(buf_count);
                  overflows++;
                  line_buf[0] = b;
                  buf_count = 1;
               end
            end
            CMD_FLUSH: begin
               if (in_raw) flush_held = 1'b1;
               else begin
                  buf_count  = 0;
                  flush_held = 1'b0;
               end
            end
            CMD_WR_TRIG: if (idx < PREFIX_CAP) trig_buf[idx] = b;
            CMD_ARM: begin
               trig_count = (len > PREFIX_CAP) ? PREFIX_CAP : len;
               trig_armed = 1'b1;
            end
            CMD_DISARM: trig_armed = 1'b0;
            CMD_RAW_ON: in_raw = 1'b1;
            CMD_RAW_OFF: begin
               in_raw = 1'b0;
               if (flush_held) begin
                  buf_count  = 0;
                  flush_held = 1'b0;
               end
            end
            default: ;
         endcase
      endfunction

      task report(string what);
         // keep the log bounded if the block goes badly wrong
         if (mismatches < 100) $display("MISMATCH at result %0d: %s", results_seen, what);
         mismatches++;
      endtask

      task check_result(framer_rsp_type got);
         framer_rsp_type want;
         results_seen++;
         if (got.kind == KIND_RAW) raw_results++;
         else line_results++;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result, byte %02h", got.value));
            return;
         end
         want = expected_q.pop_front();
         if (got.kind !== want.kind)
            report($sformatf("kind %0b, expected %0b", got.kind, want.kind));
         if (got.value !== want.value)
            report($sformatf("byte %02h, expected %02h", got.value, want.value));
         if (got.last !== want.last)
            report($sformatf("last %0b, expected %0b", got.last, want.last));
         if (got.raw !== want.raw)
            report($sformatf("raw flag %0b, expected %0b", got.raw, want.raw));
      endtask

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;

   line_framer_scoreboard sb = new();

   // stimulus-side view of the trigger table, so arming never reaches
   // entries that were never written
   logic [7:0]  trig_shadow [PREFIX_CAP];
   bit          trig_written [PREFIX_CAP];
   int unsigned items_sent = 0;
   int unsigned input_stalls = 0;
   int unsigned cycle_count = 0;
   bit          steady_tx = 1'b0;   // sender offers back to back
   bit          steady_rx = 1'b0;   // receiver always ready
   bit          hold_request = 1'b0;

   at_modem_line_framer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Gap length: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Line character: mostly printable, never a newline.
   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      if ($urandom_range(0, 3) != 0) b = 8'($urandom_range(32, 126));
      else begin
         b = 8'($urandom_range(0, 255));
         if (b == CH_LF) b = CH_CR;
      end
      return b;
   endfunction

   // Longest prefix length whose entries have all been written.
   function automatic int unsigned written_run();
      int unsigned n;
      n = 0;
      while (n < PREFIX_CAP && trig_written[n]) n++;
      return n;
   endfunction

   // Offer one request and wait for its transfer. Fields change at the
   // falling edge; the transfer is seen at the rising edge.
   task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [7:0] b,
                           input logic [5:0] idx, input logic [5:0] len);
      int unsigned gap;
      gap = steady_tx ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         req_tdata  = 24'($urandom);
         req_tuser  = 3'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {4'b0, len, idx, b};
      do @(posedge clock); while (!req_tready);
      if (cmd == CMD_WR_TRIG && idx < PREFIX_CAP) begin
         trig_shadow[idx]  = b;
         trig_written[idx] = 1'b1;
      end
      // ignored requests do not count toward the item budget
      if (cmd != CMD_UNUSED && !(cmd == CMD_WR_TRIG && idx >= PREFIX_CAP)) items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_req(CMD_RX, b, 6'($urandom), 6'($urandom));
   endtask

   task automatic send_cmd(input logic [CMD_W-1:0] cmd);
      send_req(cmd, 8'($urandom), 6'($urandom), 6'($urandom));
   endtask

   task automatic arm_trigger(input int unsigned len);
      send_req(CMD_ARM, 8'($urandom), 6'($urandom), 6'(len));
   endtask

   // Random text line of n bytes, maybe with a CR, ended by a newline.
   task automatic send_text_line(input int unsigned n);
      for (int unsigned i = 0; i < n; i++) send_byte(text_byte());
      if ($urandom_range(0, 2) == 0) send_byte(CH_CR);
      send_byte(CH_LF);
   endtask

   // Result receiver: random stalls, and one long hold-off on request.
   initial begin
      int unsigned stall;
      stall = 0;
      do @(negedge clock); while (reset);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 1'b0;
         end else if (stall > 0) begin
            rsp_tready = 1'b0;
            stall--;
         end else begin
            rsp_tready = 1'b1;
            stall = steady_rx ? 0 : pick_gap();
         end
      end
   end

   // Transfer monitor on the rising edge.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_request(req_tuser, req_tdata[7:0], req_tdata[13:8], req_tdata[19:14]);
      if (!reset && req_tvalid && !req_tready) input_stalls++;
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result('{rsp_tuser[0], rsp_tdata, rsp_tlast, rsp_tuser[1]});
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, sb.pending());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int unsigned n, k, m;
      logic [7:0]  b;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed part ---
      // trigger "AT", an out-of-range write, CR dropped, match -> raw
      send_req(CMD_WR_TRIG, 8'h41, 6'd0, 6'd0);
      send_req(CMD_WR_TRIG, 8'h54, 6'd1, 6'd0);
      send_req(CMD_WR_TRIG, 8'hFF, 6'd63, 6'd63);
      arm_trigger(2);
      send_byte(8'h41);
      send_byte(8'h54);
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_byte(CH_LF);                    // newline passes through in raw mode
      send_cmd(CMD_RAW_ON);                // begin raw while raw
      send_cmd(CMD_RAW_OFF);
      // partial line survives a raw stretch
      send_byte(8'h71);
      send_cmd(CMD_RAW_ON);
      send_byte(8'hFF);
      send_cmd(CMD_RAW_OFF);
      send_byte(CH_LF);
      // flush held during raw, done at end raw; end raw while not raw
      send_byte(8'h78);
      send_cmd(CMD_RAW_ON);
      send_cmd(CMD_FLUSH);
      send_cmd(CMD_RAW_OFF);
      send_cmd(CMD_RAW_OFF);
      send_byte(CH_LF);                    // empty line, nothing out
      // zero-length trigger hits an empty line
      arm_trigger(0);
      send_byte(CH_LF);
      send_cmd(CMD_RAW_OFF);
      send_cmd(CMD_DISARM);
      send_cmd(CMD_UNUSED);
      // flush outside raw drops the line at once
      send_byte(8'h00);
      send_cmd(CMD_FLUSH);
      send_byte(CH_LF);

      // --- full trigger table and a 63-byte matching line ---
      for (int unsigned i = 0; i < PREFIX_CAP; i++) begin
         b = text_byte();
         if (i == PREFIX_CAP - 1) b = 8'h21;   // keep the last byte from being a CR
         send_req(CMD_WR_TRIG, b, 6'(i), 6'($urandom));
      end
      arm_trigger(PREFIX_CAP);
      for (int unsigned i = 0; i < LINE_CAP; i++) send_byte(trig_shadow[i]);
      send_byte(CH_LF);
      send_cmd(CMD_RAW_OFF);
      send_text_line(70);                  // overflow before the newline

      // --- receiver holds off while the sender keeps offering ---
      hold_request = 1'b1;
      steady_tx = 1'b1;
      send_cmd(CMD_RAW_ON);
      for (int unsigned i = 0; i < 12; i++) send_byte(8'($urandom));
      send_cmd(CMD_RAW_OFF);
      send_text_line(30);
      steady_tx = 1'b0;

      // --- random part ---
      while (items_sent < ITEM_TARGET) begin
         steady_tx = ($urandom_range(0, 7) == 0);
         steady_rx = ($urandom_range(0, 7) == 0);
         case ($urandom_range(0, 99)) inside
            [0:34]: begin
               // plain line, now and then long enough to overflow
               n = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 75) : $urandom_range(0, 12);
               send_text_line(n);
            end
            [35:59]: begin
               // well-formed trigger sequence, sometimes spoiled
               k = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
               for (int unsigned i = 0; i < k; i++)
                  send_req(CMD_WR_TRIG, text_byte(), 6'(i), 6'($urandom));
               arm_trigger(k);
               m = ($urandom_range(0, 3) == 0 && k > 0) ? $urandom_range(0, k - 1) : k;
               for (int unsigned i = 0; i < k; i++) begin
                  b = trig_shadow[i];
                  if (i == m) begin
                     do b = text_byte(); while (b == trig_shadow[i]);
                  end
                  send_byte(b);
               end
               for (int unsigned i = $urandom_range(0, 5); i > 0; i--) send_byte(text_byte());
               if ($urandom_range(0, 2) == 0) send_byte(CH_CR);
               send_byte(CH_LF);
               // raw stretch: any byte values
               for (int unsigned i = $urandom_range(0, 8); i > 0; i--) send_byte(8'($urandom));
               if ($urandom_range(0, 2) == 0) send_cmd(CMD_FLUSH);
               if ($urandom_range(0, 4) == 0) send_cmd(CMD_RAW_ON);
               send_cmd(CMD_RAW_OFF);
            end
            [60:71]: begin
               // flush in the middle of a line
               for (int unsigned i = $urandom_range(0, 6); i > 0; i--) send_byte(text_byte());
               send_cmd(CMD_FLUSH);
               send_text_line($urandom_range(0, 6));
            end
            [72:83]: begin
               // explicit raw stretch around a partial line
               for (int unsigned i = $urandom_range(0, 4); i > 0; i--) send_byte(text_byte());
               send_cmd(CMD_RAW_ON);
               for (int unsigned i = $urandom_range(0, 6); i > 0; i--) send_byte(8'($urandom));
               if ($urandom_range(0, 1) == 0) send_cmd(CMD_FLUSH);
               send_cmd(CMD_RAW_OFF);
               send_byte(CH_LF);
            end
            default: begin
               // noise: any command with random fields, arming kept legal
               for (int unsigned i = $urandom_range(1, 6); i > 0; i--) begin
                  b = 8'($urandom_range(0, 7));
                  if (b[2:0] == CMD_ARM) arm_trigger($urandom_range(0, written_run()));
                  else send_req(b[2:0], 8'($urandom), 6'($urandom), 6'($urandom));
               end
               send_cmd(CMD_RAW_OFF);
            end
         endcase
      end
      steady_tx = 1'b0;
      steady_rx = 1'b0;
      @(negedge clock);
      req_tvalid = 1'b0;

      // drain; the watchdog covers a hang here
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run: %0d requests, %0d results (%0d line bytes, %0d raw bytes)",
               items_sent, sb.results_seen, sb.line_results, sb.raw_results);
      $display("Run: %0d trigger hits, %0d full-line sends, %0d input stall cycles",
               sb.trigger_hits, sb.overflows, input_stalls);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
